/* src/tsme_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tsme_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_FIND   = 3'd2,
    OP_UNION  = 3'd3,
    OP_INTER  = 3'd4,
    OP_DIFF   = 3'd5,
    OP_SUBSET = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SCMP, S_DECIDE, S_DREAD, S_DWR, S_RESP,
    S_OSCAN, S_OWAIT, S_ISCAN, S_ICMP, S_ODEC, S_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic i_inc;
    logic j_inc;
    logic set_found;
    logic decide;
    logic del_write;
    logic dec_count;
    logic next_phase;
    logic load_key;
    logic odec;
    logic flush;
    logic resp;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic phase;
    logic i_lt;
    logic j_lt;
    logic hit;
    logic found;
  } stat_t;

endpackage
`default_nettype wire

/* src/tsme_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module tsme_ctrl
  import tsme_pkg::*;
(
  input  state_t state,
  input  wire    start,
  input  stat_t  st,
  output cmd_t   cmd,
  output logic   busy
);

  // Command decode for each controller state.
  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE:   cmd.load = start;
      S_SCMP, S_ICMP: begin
        if (st.hit) cmd.set_found = 1'b1;
        else        cmd.j_inc     = 1'b1;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.j_inc  = (st.op == OP_DELETE && st.found);
      end
      S_DREAD:  cmd.dec_count = !st.j_lt;
      S_DWR: begin
        cmd.del_write = 1'b1;
        cmd.j_inc     = 1'b1;
      end
      S_RESP:   cmd.resp = 1'b1;
      S_OSCAN:  cmd.next_phase = !st.i_lt && st.op == OP_UNION && !st.phase;
      S_OWAIT:  cmd.load_key = 1'b1;
      S_ODEC: begin
        cmd.odec  = 1'b1;
        cmd.i_inc = 1'b1;
      end
      S_FLUSH:  cmd.flush = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

/* src/tsme_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module tsme_datapath
  import tsme_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire  [2:0]  op,
  input  wire         which_set,
  input  wire  [31:0] value,
  input  cmd_t        cmd,
  output stat_t       st,
  output logic        valid,
  output logic [31:0] member,
  output logic        has_member,
  output logic        answer,
  output logic [4:0]  count,
  output logic [1:0]  status,
  output logic        last
);

  logic [31:0] mem_a [CAPACITY];
  logic [31:0] mem_b [CAPACITY];
  logic [31:0] rd_a, rd_b;

  op_t         op_r;
  logic        sel, phase, found, ans, pend_valid;
  logic [31:0] key, pend;
  status_t     stat_r;
  cnt_t        count_a, count_b, i, j;

  logic        outer_b, we_a, we_b;
  idx_t        addr_a, addr_b, waddr;
  logic [31:0] wdata, rd_outer, rd_inner;
  cnt_t        lc, rn, n_in, n_out;
  logic        full, take;

  assign outer_b  = sel ^ phase;
  assign addr_a   = outer_b ? j[IDX_W-1:0] : i[IDX_W-1:0];
  assign addr_b   = outer_b ? i[IDX_W-1:0] : j[IDX_W-1:0];
  assign rd_outer = outer_b ? rd_b : rd_a;
  assign rd_inner = outer_b ? rd_a : rd_b;
  assign lc       = sel ? count_b : count_a;
  assign rn       = sel ? count_a : count_b;
  assign n_out    = phase ? rn : lc;
  assign n_in     = phase ? lc : rn;
  assign full     = (lc >= CNT_W'(CAPACITY));

  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    waddr = lc[IDX_W-1:0];
    wdata = key;
    if (cmd.decide && op_r == OP_INSERT && !found && !full) begin
      we_a = !sel;
      we_b = sel;
    end
    if (cmd.del_write) begin
      waddr = idx_t'(j - 1'b1);
      wdata = rd_inner;
      we_a  = !sel;
      we_b  = sel;
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) mem_a[waddr] <= wdata;
    rd_a <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[waddr] <= wdata;
    rd_b <= mem_b[addr_b];
  end

  always_comb begin
    case (op_r)
      OP_UNION: take = !phase || !found;
      OP_INTER: take = found;
      OP_DIFF:  take = !found;
      default:  take = 1'b0;
    endcase
  end

  always_comb begin
    st.op    = op_r;
    st.phase = phase;
    st.i_lt  = (i < n_out);
    st.j_lt  = (j < n_in);
    st.hit   = (rd_inner == key);
    st.found = found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a    <= '0;
      count_b    <= '0;
      valid      <= 1'b0;
      pend_valid <= 1'b0;
      op_r       <= OP_NONE;
      phase      <= 1'b0;
    end else begin
      valid <= (cmd.odec && take && pend_valid) || cmd.flush || cmd.resp;
      if (cmd.load) begin
        op_r       <= op_t'(op);
        sel        <= which_set;
        key        <= value;
        phase      <= (op_t'(op) == OP_INSERT || op_t'(op) == OP_DELETE ||
                       op_t'(op) == OP_FIND);
        i          <= '0;
        j          <= '0;
        found      <= 1'b0;
        ans        <= (op_t'(op) == OP_SUBSET);
        stat_r     <= ST_OK;
        pend_valid <= 1'b0;
      end
      if (cmd.i_inc)     i <= i + 1'b1;
      if (cmd.j_inc)     j <= j + 1'b1;
      if (cmd.set_found) found <= 1'b1;
      if (cmd.next_phase) begin
        phase <= 1'b1;
        i     <= '0;
      end
      if (cmd.load_key) begin
        key   <= rd_outer;
        j     <= '0;
        found <= 1'b0;
      end
      if (cmd.decide) begin
        case (op_r)
          OP_INSERT: begin
            if (found)     stat_r <= ST_PRESENT;
            else if (full) stat_r <= ST_FULL;
            else begin
              if (sel) count_b <= count_b + 1'b1;
              else     count_a <= count_a + 1'b1;
            end
          end
          OP_DELETE: if (!found) stat_r <= ST_MISSING;
          OP_FIND:   ans <= found;
          default:   ;
        endcase
      end
      if (cmd.dec_count) begin
        if (sel) count_b <= count_b - 1'b1;
        else     count_a <= count_a - 1'b1;
      end
      if (cmd.odec) begin
        if (op_r == OP_SUBSET && !found) ans <= 1'b0;
        if (take) begin
          if (pend_valid) begin
            member     <= pend;
            has_member <= 1'b1;
            answer     <= 1'b0;
            count      <= 5'(lc);
            status     <= ST_OK;
            last       <= 1'b0;
          end
          pend       <= key;
          pend_valid <= 1'b1;
        end
      end
      if (cmd.flush) begin
        member     <= pend_valid ? pend : 32'd0;
        has_member <= pend_valid;
        answer     <= 1'b0;
        count      <= 5'(lc);
        status     <= ST_OK;
        last       <= 1'b1;
      end
      if (cmd.resp) begin
        member     <= 32'd0;
        has_member <= 1'b0;
        answer     <= ans;
        count      <= 5'(lc);
        status     <= stat_r;
        last       <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/tsme_dispatch.sv */
`timescale 1ns / 1ps
`default_nettype none
module tsme_dispatch
  import tsme_pkg::*;
(
  input  wire  [2:0] op,
  output state_t     first
);

  always_comb begin
    case (op_t'(op))
      OP_INSERT, OP_DELETE, OP_FIND:                 first = S_SRCH;
      OP_UNION, OP_INTER, OP_DIFF, OP_SUBSET:        first = S_OSCAN;
      default:                                       first = S_RESP;
    endcase
  end

endmodule
`default_nettype wire

/* src/tsme_fsm.sv */
`timescale 1ns / 1ps
`default_nettype none
module tsme_fsm
  import tsme_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  wire  [2:0] op,
  input  stat_t      st,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state, state_next, first;

  tsme_dispatch u_dispatch (
    .op    (op),
    .first (first)
  );

  // Commands and busy are decoded from the current state, start and the datapath status.
  tsme_ctrl u_ctrl (
    .state (state),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    case (state)
      S_IDLE:   state_next = start ? first : S_IDLE;
      S_SRCH:   state_next = st.j_lt ? S_SCMP : S_DECIDE;
      S_SCMP:   state_next = st.hit ? S_DECIDE : S_SRCH;
      S_DECIDE: state_next = (st.op == OP_DELETE && st.found) ? S_DREAD : S_RESP;
      S_DREAD:  state_next = st.j_lt ? S_DWR : S_RESP;
      S_DWR:    state_next = S_DREAD;
      S_RESP:   state_next = S_IDLE;
      S_OSCAN: begin
        if (st.i_lt)                             state_next = S_OWAIT;
        else if (st.op == OP_UNION && !st.phase) state_next = S_OSCAN;
        else if (st.op == OP_SUBSET)             state_next = S_RESP;
        else                                     state_next = S_FLUSH;
      end
      S_OWAIT:  state_next = S_ISCAN;
      S_ISCAN:  state_next = st.j_lt ? S_ICMP : S_ODEC;
      S_ICMP:   state_next = st.hit ? S_ODEC : S_ISCAN;
      S_ODEC:   state_next = S_OSCAN;
      S_FLUSH:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* src/two_set_membership_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// Insert, delete and find search the addressed set, a delete then shifting later members down;
// the unused opcode goes straight to the response. Intersection, difference and subset scan
// the other set once per member of the addressed set, and a union scans both ways.
// The final result appears as busy falls.
// One transaction at a time; results are strobed on valid for one cycle and cannot be stalled.
// Synchronous active-high reset empties both sets; stored members need no clearing.
module two_set_membership_engine
  import tsme_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [2:0]  op,
  input  wire         which_set,
  input  wire  [31:0] value,
  output logic        busy,
  output logic        valid,
  output logic [31:0] member,
  output logic        has_member,
  output logic        answer,
  output logic [4:0]  count,
  output logic [1:0]  status,
  output logic        last
);

  // The controller sequences the scans; the datapath holds both member
  // memories, the counts, the scan indexes and the result registers.
  cmd_t  cmd;
  stat_t st;

  tsme_fsm u_fsm (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Stream results are held back by one member so that the final one can
  // carry the last mark; an empty stream gives a single memberless result.
  tsme_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .which_set  (which_set),
    .value      (value),
    .cmd        (cmd),
    .st         (st),
    .valid      (valid),
    .member     (member),
    .has_member (has_member),
    .answer     (answer),
    .count      (count),
    .status     (status),
    .last       (last)
  );

endmodule
`default_nettype wire
